### sv/tbr_pkg.sv
// shared types, constants and edge math for the block rasterizer
package tbr_pkg;

   localparam int FB_WIDTH_DEF   = 256;
   localparam int FB_HEIGHT_DEF  = 256;
   localparam int BLOCK_SIZE_DEF = 8;
   localparam int COORD_W        = 12;
   localparam int ROW_W          = 5;
   localparam int COL_LIMIT      = 32;
   localparam int EDGE_W         = 40;
   localparam int DIFF_W         = 13;
   localparam int PIX_W          = 13;
   localparam int PROD_W         = DIFF_W + PIX_W + 6;
   localparam int RECIP_SHIFT    = 16;
   localparam int QUEUE_DEPTH    = 2;
   localparam logic [3:0] ROUND_UP = 4'hF;

   typedef logic signed [EDGE_W-1:0] edge_val_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      edge_val_type             c;
   } edge_type;

   typedef struct packed {
      edge_type   e0;
      edge_type   e1;
      edge_type   e2;
      logic [PIX_W-1:0] minx;
      logic [PIX_W-1:0] maxx;
      logic [ROW_W-1:0] row;
      logic             row_ok;
   } setup_type;

   function automatic logic edge_in(edge_type e, logic [PIX_W-1:0] px,
                                    logic [PIX_W-1:0] py);
      logic signed [PROD_W-1:0] ty, tx;
      edge_val_type v;
      ty = PROD_W'(e.dx) * PROD_W'($signed({1'b0, py, 4'b0}));
      tx = PROD_W'(e.dy) * PROD_W'($signed({1'b0, px, 4'b0}));
      v = e.c + EDGE_W'(ty) - EDGE_W'(tx);
      return v > 0;
   endfunction

   // divide by the block size through its reciprocal, exact for pixel values
   function automatic logic [PIX_W-1:0] blk_div(logic [PIX_W-1:0] v,
                                                logic [RECIP_SHIFT:0] recip);
      logic [PIX_W+RECIP_SHIFT:0] p;
      p = {{(RECIP_SHIFT+1){1'b0}}, v} * {{PIX_W{1'b0}}, recip};
      return PIX_W'(p >> RECIP_SHIFT);
   endfunction

endpackage

### sv/triangle_block_rasterizer.sv
// top level: setup front, queue and block walker back
// path: front setup register, queue, walker load, one walker step per block column in
// the box and a closing step for the row, which loads the last result for output
// the walker takes a new triangle row only once idle; front and queue hold the rows behind
// the block walker sets the rate, evaluating one 8x8 block per cycle unless the output stalls it
// reset: synchronous active high, empties queue and output, fill color to all ones
module triangle_block_rasterizer #(
   parameter int FB_WIDTH   = tbr_pkg::FB_WIDTH_DEF,
   parameter int FB_HEIGHT  = tbr_pkg::FB_HEIGHT_DEF,
   parameter int BLOCK_SIZE = tbr_pkg::BLOCK_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [tbr_pkg::COORD_W-1:0] req_vert_a_x,
   input  logic [tbr_pkg::COORD_W-1:0] req_vert_a_y,
   input  logic [tbr_pkg::COORD_W-1:0] req_vert_b_x,
   input  logic [tbr_pkg::COORD_W-1:0] req_vert_b_y,
   input  logic [tbr_pkg::COORD_W-1:0] req_vert_c_x,
   input  logic [tbr_pkg::COORD_W-1:0] req_vert_c_y,
   input  logic [tbr_pkg::ROW_W-1:0]   req_block_row,
   output logic                      empty,
   input  logic                      pop,
   output logic [tbr_pkg::ROW_W-1:0] rsp_block_col,
   output logic [tbr_pkg::ROW_W-1:0] rsp_block_line,
   output logic [63:0]               rsp_coverage,
   output logic                      rsp_full_block,
   output logic [31:0]               rsp_color_out,
   output logic                      rsp_empty_res,
   output logic                      rsp_last,
   input  logic                      csr_we,
   input  logic [31:0]               csr_wdata
);
   import tbr_pkg::*;

   logic        in_ready, f_valid, f_ready, q_valid, q_ready;
   setup_type   f_data, q_data;
   logic [31:0] color_ff;

   always_ff @(posedge clock) begin
      if (reset) color_ff <= '1;
      else if (csr_we) color_ff <= csr_wdata;
   end

   assign full = !in_ready;

   tbr_front #(.FB_HEIGHT(FB_HEIGHT), .BLOCK_SIZE(BLOCK_SIZE)) u_front (
      .clock, .reset, .in_valid(push), .in_ready,
      .ax(req_vert_a_x), .ay(req_vert_a_y), .bx(req_vert_b_x), .by(req_vert_b_y),
      .cx(req_vert_c_x), .cy(req_vert_c_y), .row(req_block_row),
      .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
   );

   tbr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   tbr_back #(.FB_WIDTH(FB_WIDTH), .BLOCK_SIZE(BLOCK_SIZE)) u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .color(color_ff), .out_empty(empty), .out_pop(pop),
      .out_col(rsp_block_col), .out_line(rsp_block_line), .out_cov(rsp_coverage),
      .out_full(rsp_full_block), .out_color(rsp_color_out),
      .out_empty_res(rsp_empty_res), .out_last(rsp_last)
   );

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_empty_res |-> rsp_last && rsp_coverage == '0)
      else $error("empty result not terminal");
   a_full_mask: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_full_block |-> !rsp_empty_res && rsp_coverage != '0)
      else $error("full block without coverage");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_coverage) && $stable(rsp_last))
      else $error("result changed while stalled");
endmodule

### sv/tbr_front.sv
// triangle setup: edge functions, bounding box, row check
module tbr_front #(
   parameter int FB_HEIGHT  = tbr_pkg::FB_HEIGHT_DEF,
   parameter int BLOCK_SIZE = tbr_pkg::BLOCK_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [tbr_pkg::COORD_W-1:0]      ax, ay, bx, by, cx, cy,
   input  logic [tbr_pkg::ROW_W-1:0]        row,
   output logic                             out_valid,
   input  logic                             out_ready,
   output tbr_pkg::setup_type               out_data
);
   import tbr_pkg::*;

   localparam logic [RECIP_SHIFT:0] BLK_RECIP =
      (RECIP_SHIFT+1)'(((1 << RECIP_SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE);

   setup_type data_ff, data_in;
   logic      valid_ff;

   function automatic edge_type make_edge(logic [COORD_W-1:0] xi, logic [COORD_W-1:0] yi,
                                          logic [COORD_W-1:0] xj, logic [COORD_W-1:0] yj);
      edge_type e;
      logic signed [2*DIFF_W-1:0] p, q;
      e.dx = $signed({1'b0, xi}) - $signed({1'b0, xj});
      e.dy = $signed({1'b0, yi}) - $signed({1'b0, yj});
      p = (2*DIFF_W)'(e.dy) * (2*DIFF_W)'($signed({1'b0, xi}));
      q = (2*DIFF_W)'(e.dx) * (2*DIFF_W)'($signed({1'b0, yi}));
      e.c = EDGE_W'(p) - EDGE_W'(q);
      if (e.dy < 0 || (e.dy == 0 && e.dx > 0)) e.c = e.c + EDGE_W'(1);
      return e;
   endfunction

   function automatic logic [PIX_W-1:0] pix(logic [COORD_W-1:0] v);
      logic [COORD_W:0] s;
      s = {1'b0, v} + {{(COORD_W-3){1'b0}}, ROUND_UP};
      return PIX_W'(s >> 4);
   endfunction

   logic [COORD_W-1:0] mnx, mxx, mny, mxy;
   logic [PIX_W-1:0]   miny_a, ypix, minx_p;

   always_comb begin
      mnx = ax; mxx = ax; mny = ay; mxy = ay;
      if (bx < mnx) mnx = bx;
      if (cx < mnx) mnx = cx;
      if (bx > mxx) mxx = bx;
      if (cx > mxx) mxx = cx;
      if (by < mny) mny = by;
      if (cy < mny) mny = cy;
      if (by > mxy) mxy = by;
      if (cy > mxy) mxy = cy;
      minx_p = pix(mnx);
      miny_a = blk_div(pix(mny), BLK_RECIP) * PIX_W'(BLOCK_SIZE);
      ypix   = PIX_W'(row) * PIX_W'(BLOCK_SIZE);
      data_in.e0   = make_edge(ax, ay, bx, by);
      data_in.e1   = make_edge(bx, by, cx, cy);
      data_in.e2   = make_edge(cx, cy, ax, ay);
      data_in.minx = blk_div(minx_p, BLK_RECIP) * PIX_W'(BLOCK_SIZE);
      data_in.maxx = pix(mxx);
      data_in.row  = row;
      data_in.row_ok = (ypix >= miny_a) && (ypix < pix(mxy))
                       && (32'(ypix) < 32'(FB_HEIGHT));
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end
endmodule

### sv/tbr_queue.sv
// short queue between setup and block walker
module tbr_queue #(
   parameter int DEPTH = tbr_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  tbr_pkg::setup_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output tbr_pkg::setup_type out_data
);
   import tbr_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   setup_type         mem_ff [DEPTH];
   logic [AW-1:0]     wr_ff, rd_ff;
   logic [AW:0]       cnt_ff;
   logic              push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + AW'(1);
         if (pop)  rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + AW'(1);
         if (push && !pop) cnt_ff <= cnt_ff + (AW+1)'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - (AW+1)'(1);
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

### sv/tbr_back.sv
// block walker: corner tests and coverage, one block per cycle unless the output stalls it
module tbr_back #(
   parameter int FB_WIDTH   = tbr_pkg::FB_WIDTH_DEF,
   parameter int BLOCK_SIZE = tbr_pkg::BLOCK_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  tbr_pkg::setup_type          in_data,
   input  logic [31:0]                 color,
   output logic                        out_empty,
   input  logic                        out_pop,
   output logic [tbr_pkg::ROW_W-1:0]   out_col,
   output logic [tbr_pkg::ROW_W-1:0]   out_line,
   output logic [63:0]                 out_cov,
   output logic                        out_full,
   output logic [31:0]                 out_color,
   output logic                        out_empty_res,
   output logic                        out_last
);
   import tbr_pkg::*;

   localparam logic [RECIP_SHIFT:0] BLK_RECIP =
      (RECIP_SHIFT+1)'(((1 << RECIP_SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE);

   typedef enum logic [1:0] {ST_IDLE = 2'b01, ST_WALK = 2'b10} state_type;

   state_type        state_ff;
   setup_type        job_ff;
   logic [PIX_W-1:0] x_ff;
   logic             any_ff;
   // one held result while the next block is evaluated
   logic             hold_ff;
   logic [ROW_W-1:0] h_col_ff;
   logic [63:0]      h_cov_ff;
   logic             h_full_ff;
   logic [31:0]      h_color_ff;
   logic             h_emp_ff;
   // output register
   logic             ov_ff;
   logic [ROW_W-1:0] o_col_ff, o_line_ff;
   logic [63:0]      o_cov_ff;
   logic             o_full_ff, o_emp_ff, o_last_ff;
   logic [31:0]      o_color_ff;

   logic [PIX_W-1:0] y, xe, ye;
   logic [3:0]       ca, cb, cc;
   logic             step_ok, survive, full, walk_done, out_free, can_step, out_load;
   logic [63:0]      mask;

   always_comb begin
      y  = PIX_W'(job_ff.row) * PIX_W'(BLOCK_SIZE);
      xe = x_ff + PIX_W'(BLOCK_SIZE - 1);
      ye = y + PIX_W'(BLOCK_SIZE - 1);
      ca = {edge_in(job_ff.e0, xe, ye), edge_in(job_ff.e0, x_ff, ye),
            edge_in(job_ff.e0, xe, y), edge_in(job_ff.e0, x_ff, y)};
      cb = {edge_in(job_ff.e1, xe, ye), edge_in(job_ff.e1, x_ff, ye),
            edge_in(job_ff.e1, xe, y), edge_in(job_ff.e1, x_ff, y)};
      cc = {edge_in(job_ff.e2, xe, ye), edge_in(job_ff.e2, x_ff, ye),
            edge_in(job_ff.e2, xe, y), edge_in(job_ff.e2, x_ff, y)};
      step_ok = job_ff.row_ok && (x_ff < job_ff.maxx) && (32'(x_ff) < 32'(FB_WIDTH))
                && (blk_div(x_ff, BLK_RECIP) < PIX_W'(COL_LIMIT));
      survive = (ca != '0) && (cb != '0) && (cc != '0);
      full = (ca == 4'hF) && (cb == 4'hF) && (cc == 4'hF);
      mask = '0;
      for (int iy = 0; iy < BLOCK_SIZE; iy++) begin
         for (int ix = 0; ix < BLOCK_SIZE; ix++) begin
            if (full || (edge_in(job_ff.e0, x_ff + PIX_W'(ix), y + PIX_W'(iy))
                      && edge_in(job_ff.e1, x_ff + PIX_W'(ix), y + PIX_W'(iy))
                      && edge_in(job_ff.e2, x_ff + PIX_W'(ix), y + PIX_W'(iy))))
               mask[iy*8+ix] = 1'b1;
         end
      end
      walk_done = !step_ok;
      out_free  = !ov_ff || out_pop;
      // a held result moves out only when the next one is known or the walk ends
      can_step  = state_ff == ST_WALK && (!hold_ff || out_free);
      out_load  = can_step && ((walk_done && (hold_ff || !any_ff) && out_free)
                               || (!walk_done && survive && hold_ff));
   end

   assign in_ready = state_ff == ST_IDLE;
   assign out_empty = !ov_ff;
   assign out_col = o_col_ff;
   assign out_line = o_line_ff;
   assign out_cov = o_cov_ff;
   assign out_full = o_full_ff;
   assign out_color = o_color_ff;
   assign out_empty_res = o_emp_ff;
   assign out_last = o_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hold_ff  <= 1'b0;
         ov_ff    <= 1'b0;
         any_ff   <= 1'b0;
      end else begin
         if (out_load) ov_ff <= 1'b1;
         else if (out_pop) ov_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  state_ff <= ST_WALK;
                  job_ff   <= in_data;
                  x_ff     <= in_data.minx;
                  any_ff   <= 1'b0;
               end
            end
            ST_WALK: begin
               if (can_step) begin
                  if (walk_done) begin
                     if (hold_ff || !any_ff) begin
                        if (out_free) begin
                           o_col_ff   <= hold_ff ? h_col_ff : '0;
                           o_line_ff  <= job_ff.row;
                           o_cov_ff   <= hold_ff ? h_cov_ff : '0;
                           o_full_ff  <= hold_ff ? h_full_ff : 1'b0;
                           o_color_ff <= hold_ff ? h_color_ff : '0;
                           o_emp_ff   <= hold_ff ? h_emp_ff : 1'b1;
                           o_last_ff  <= 1'b1;
                           hold_ff    <= 1'b0;
                           state_ff   <= ST_IDLE;
                        end
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end else begin
                     x_ff <= x_ff + PIX_W'(BLOCK_SIZE);
                     if (survive) begin
                        if (hold_ff) begin
                           o_col_ff   <= h_col_ff;
                           o_line_ff  <= job_ff.row;
                           o_cov_ff   <= h_cov_ff;
                           o_full_ff  <= h_full_ff;
                           o_color_ff <= h_color_ff;
                           o_emp_ff   <= h_emp_ff;
                           o_last_ff  <= 1'b0;
                        end
                        hold_ff    <= 1'b1;
                        any_ff     <= 1'b1;
                        h_col_ff   <= ROW_W'(blk_div(x_ff, BLK_RECIP));
                        h_cov_ff   <= mask;
                        h_full_ff  <= full;
                        h_color_ff <= color;
                        h_emp_ff   <= 1'b0;
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
